[hdl/cau_pkg.sv]
// Shared types, constants and helper functions of the complex arithmetic unit.
`default_nettype none

package cau_pkg;

   localparam int WORD_BITS  = 32;
   localparam int FRAC_BITS  = 16;
   localparam int ACT_BITS   = 3;
   localparam int PROD_BITS  = 2 * WORD_BITS;
   localparam int SUM_BITS   = PROD_BITS + 1;
   localparam int DIV_STEPS  = PROD_BITS + FRAC_BITS + 1;
   localparam int SQRT_STEPS = WORD_BITS;
   localparam int QUO_BITS   = WORD_BITS + 2;
   localparam int REQ_DATA_BITS = 4 * WORD_BITS;
   localparam int RSP_DATA_BITS = ((2 * WORD_BITS + 1 + 7) / 8) * 8;

   localparam logic [PROD_BITS-1:0] HALF_LSB = (PROD_BITS'(1) << FRAC_BITS) >> 1;
   localparam logic [PROD_BITS-1:0] NEG_LIMIT = PROD_BITS'(1) << (WORD_BITS - 1);
   localparam logic [PROD_BITS-1:0] POS_LIMIT = NEG_LIMIT - PROD_BITS'(1);
   localparam logic [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam logic [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

   typedef enum logic [ACT_BITS-1:0] {
      ACT_ADD = 3'd0,
      ACT_SUB = 3'd1,
      ACT_MUL = 3'd2,
      ACT_DIV = 3'd3,
      ACT_EQ  = 3'd4,
      ACT_MAG = 3'd5
   } action_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_DIV_ZERO = 2'd1,
      STAT_SAT      = 2'd2
   } status_type;

   // Per-item result and control that travels beside the datapath
   typedef struct packed {
      logic                 is_mul;
      logic                 is_div;
      logic                 is_mag;
      logic                 dz;
      logic                 nr;
      logic                 ni;
      logic [WORD_BITS-1:0] re;
      logic [WORD_BITS-1:0] im;
      status_type           status;
      logic                 eq;
   } side_type;

   // One lane of the restoring divider
   typedef struct packed {
      logic [PROD_BITS-1:0] num;
      logic [PROD_BITS-1:0] rem;
      logic [QUO_BITS-1:0]  q;
      logic                 big;
   } div_lane_type;

   // Digit-by-digit square root state
   typedef struct packed {
      logic [PROD_BITS-1:0] x;
      logic [WORD_BITS+1:0] rem;
      logic [WORD_BITS-1:0] root;
   } sqrt_lane_type;

   typedef struct packed {
      logic                 sat;
      logic [WORD_BITS-1:0] value;
   } clamp_type;

   // Clamp a sign and magnitude into the signed word range
   function automatic clamp_type clamp_word(input logic neg, input logic [PROD_BITS-1:0] mag);
      clamp_type c;
      c.sat = 1'b0;
      if (neg) begin
         if (mag > NEG_LIMIT) begin
            c.sat   = 1'b1;
            c.value = WORD_MIN;
         end else begin
            c.value = WORD_BITS'(PROD_BITS'(0) - mag);
         end
      end else begin
         if (mag > POS_LIMIT) begin
            c.sat   = 1'b1;
            c.value = WORD_MAX;
         end else begin
            c.value = mag[WORD_BITS-1:0];
         end
      end
      return c;
   endfunction

   // Clamp a one-bit-wider signed sum into the word range
   function automatic clamp_type sat_sum(input logic [WORD_BITS:0] s);
      clamp_type c;
      c.sat   = (s[WORD_BITS] != s[WORD_BITS-1]);
      c.value = s[WORD_BITS-1:0];
      if (c.sat) begin
         c.value = s[WORD_BITS] ? WORD_MIN : WORD_MAX;
      end
      return c;
   endfunction

endpackage

`default_nettype wire

[hdl/cau_front.sv]
// Front end: products, sums, magnitudes, add/sub/compare and multiply rounding (4 stages).
`default_nettype none

module cau_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              adv,
   input  logic                              in_valid,
   input  logic [cau_pkg::ACT_BITS-1:0]      in_action,
   input  logic [cau_pkg::WORD_BITS-1:0]     in_a_re,
   input  logic [cau_pkg::WORD_BITS-1:0]     in_a_im,
   input  logic [cau_pkg::WORD_BITS-1:0]     in_b_re,
   input  logic [cau_pkg::WORD_BITS-1:0]     in_b_im,
   output logic                              out_valid,
   output cau_pkg::side_type                 out_side,
   output cau_pkg::div_lane_type             out_lane_re,
   output cau_pkg::div_lane_type             out_lane_im,
   output logic [cau_pkg::PROD_BITS-1:0]     out_divisor
);
   import cau_pkg::*;

   // Stage A: products
   logic signed [WORD_BITS-1:0] ar, ai, br, bi, xsel, ysel;
   logic signed [PROD_BITS-1:0] prod_in [6];
   logic                        a_valid_ff;
   logic [ACT_BITS-1:0]         a_action_ff;
   logic [WORD_BITS-1:0]        a_ar_ff, a_ai_ff, a_br_ff, a_bi_ff;
   logic signed [PROD_BITS-1:0] prod_ff [6];

   // Stage B: sums and simple results
   logic [WORD_BITS:0]          s_re, s_im;
   clamp_type                   c_add_re, c_add_im;
   side_type                    b_side_in;
   logic signed [SUM_BITS-1:0]  b_re_sum_in, b_im_sum_in;
   logic [PROD_BITS-1:0]        b_divisor_in;
   logic                        b_valid_ff;
   side_type                    b_side_ff;
   logic signed [SUM_BITS-1:0]  b_re_sum_ff, b_im_sum_ff;
   logic [PROD_BITS-1:0]        b_divisor_ff;

   // Stage C: magnitudes
   logic [SUM_BITS-1:0]         abs_re, abs_im;
   side_type                    c_side_in;
   logic                        c_valid_ff;
   side_type                    c_side_ff;
   logic [PROD_BITS-1:0]        c_mag_re_ff, c_mag_im_ff;
   logic [PROD_BITS-1:0]        c_divisor_ff;

   // Stage D: multiply rounding and clamp
   logic [PROD_BITS-1:0]        rnd_re, rnd_im;
   clamp_type                   c_mul_re, c_mul_im;
   side_type                    d_side_in;
   div_lane_type                d_lane_re_in, d_lane_im_in;
   logic                        d_valid_ff;
   side_type                    d_side_ff;
   div_lane_type                d_lane_re_ff, d_lane_im_ff;
   logic [PROD_BITS-1:0]        d_divisor_ff;

   // Select multiplier operands; magnitude squares a
   always_comb begin
      ar   = in_a_re;
      ai   = in_a_im;
      br   = in_b_re;
      bi   = in_b_im;
      xsel = (in_action == ACT_MAG) ? ar : br;
      ysel = (in_action == ACT_MAG) ? ai : bi;
      prod_in[0] = PROD_BITS'(ar) * PROD_BITS'(xsel);
      prod_in[1] = PROD_BITS'(ai) * PROD_BITS'(ysel);
      prod_in[2] = PROD_BITS'(ar) * PROD_BITS'(bi);
      prod_in[3] = PROD_BITS'(ai) * PROD_BITS'(br);
      prod_in[4] = PROD_BITS'(br) * PROD_BITS'(br);
      prod_in[5] = PROD_BITS'(bi) * PROD_BITS'(bi);
   end

   // Stage B combine
   always_comb begin
      if (a_action_ff == ACT_SUB) begin
         s_re = {a_ar_ff[WORD_BITS-1], a_ar_ff} - {a_br_ff[WORD_BITS-1], a_br_ff};
         s_im = {a_ai_ff[WORD_BITS-1], a_ai_ff} - {a_bi_ff[WORD_BITS-1], a_bi_ff};
      end else begin
         s_re = {a_ar_ff[WORD_BITS-1], a_ar_ff} + {a_br_ff[WORD_BITS-1], a_br_ff};
         s_im = {a_ai_ff[WORD_BITS-1], a_ai_ff} + {a_bi_ff[WORD_BITS-1], a_bi_ff};
      end
      c_add_re = sat_sum(s_re);
      c_add_im = sat_sum(s_im);

      b_side_in = '0;
      unique case (a_action_ff) inside
         ACT_ADD, ACT_SUB: begin
            b_side_in.re     = c_add_re.value;
            b_side_in.im     = c_add_im.value;
            b_side_in.status = (c_add_re.sat || c_add_im.sat) ? STAT_SAT : STAT_OK;
         end
         ACT_MUL: b_side_in.is_mul = 1'b1;
         ACT_DIV: begin
            b_side_in.is_div = 1'b1;
            b_side_in.dz     = (a_br_ff == '0) && (a_bi_ff == '0);
         end
         ACT_EQ:  b_side_in.eq = (a_ar_ff == a_br_ff) && (a_ai_ff == a_bi_ff);
         ACT_MAG: b_side_in.is_mag = 1'b1;
         default: ;
      endcase

      if (a_action_ff == ACT_MUL) begin
         b_re_sum_in = SUM_BITS'(prod_ff[0]) - SUM_BITS'(prod_ff[1]);
         b_im_sum_in = SUM_BITS'(prod_ff[2]) + SUM_BITS'(prod_ff[3]);
      end else begin
         b_re_sum_in = SUM_BITS'(prod_ff[0]) + SUM_BITS'(prod_ff[1]);
         b_im_sum_in = SUM_BITS'(prod_ff[3]) - SUM_BITS'(prod_ff[2]);
      end
      b_divisor_in = $unsigned(prod_ff[4]) + $unsigned(prod_ff[5]);
   end

   // Stage C: sign and magnitude
   always_comb begin
      abs_re = b_re_sum_ff[SUM_BITS-1] ? SUM_BITS'(-b_re_sum_ff) : SUM_BITS'(b_re_sum_ff);
      abs_im = b_im_sum_ff[SUM_BITS-1] ? SUM_BITS'(-b_im_sum_ff) : SUM_BITS'(b_im_sum_ff);
      c_side_in    = b_side_ff;
      c_side_in.nr = b_re_sum_ff[SUM_BITS-1];
      c_side_in.ni = b_im_sum_ff[SUM_BITS-1];
   end

   // Stage D: round multiply results, load divider lanes
   always_comb begin
      rnd_re   = (c_mag_re_ff + HALF_LSB) >> FRAC_BITS;
      rnd_im   = (c_mag_im_ff + HALF_LSB) >> FRAC_BITS;
      c_mul_re = clamp_word(c_side_ff.nr, rnd_re);
      c_mul_im = clamp_word(c_side_ff.ni, rnd_im);
      d_side_in = c_side_ff;
      if (c_side_ff.is_mul) begin
         d_side_in.re     = c_mul_re.value;
         d_side_in.im     = c_mul_im.value;
         d_side_in.status = (c_mul_re.sat || c_mul_im.sat) ? STAT_SAT : STAT_OK;
      end
      d_lane_re_in     = '0;
      d_lane_re_in.num = c_mag_re_ff;
      d_lane_im_in     = '0;
      d_lane_im_in.num = c_mag_im_ff;
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (adv) begin
         a_action_ff  <= in_action;
         a_ar_ff      <= in_a_re;
         a_ai_ff      <= in_a_im;
         a_br_ff      <= in_b_re;
         a_bi_ff      <= in_b_im;
         prod_ff      <= prod_in;
         b_side_ff    <= b_side_in;
         b_re_sum_ff  <= b_re_sum_in;
         b_im_sum_ff  <= b_im_sum_in;
         b_divisor_ff <= b_divisor_in;
         c_side_ff    <= c_side_in;
         c_mag_re_ff  <= abs_re[PROD_BITS-1:0];
         c_mag_im_ff  <= abs_im[PROD_BITS-1:0];
         c_divisor_ff <= b_divisor_ff;
         d_side_ff    <= d_side_in;
         d_lane_re_ff <= d_lane_re_in;
         d_lane_im_ff <= d_lane_im_in;
         d_divisor_ff <= c_divisor_ff;
      end
   end

   assign out_valid   = d_valid_ff;
   assign out_side    = d_side_ff;
   assign out_lane_re = d_lane_re_ff;
   assign out_lane_im = d_lane_im_ff;
   assign out_divisor = d_divisor_ff;

endmodule

`default_nettype wire

[hdl/cau_divsqrt.sv]
// Pipelined restoring divider (two lanes) and digit-by-digit square root, one bit per stage.
`default_nettype none

module cau_divsqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  cau_pkg::side_type             in_side,
   input  cau_pkg::div_lane_type         in_lane_re,
   input  cau_pkg::div_lane_type         in_lane_im,
   input  logic [cau_pkg::PROD_BITS-1:0] in_divisor,
   output logic                          out_valid,
   output cau_pkg::side_type             out_side,
   output cau_pkg::div_lane_type         out_lane_re,
   output cau_pkg::div_lane_type         out_lane_im
);
   import cau_pkg::*;

   logic                 valid_ff   [DIV_STEPS];
   side_type             side_ff    [DIV_STEPS];
   div_lane_type         re_ff      [DIV_STEPS];
   div_lane_type         im_ff      [DIV_STEPS];
   logic [PROD_BITS-1:0] divisor_ff [DIV_STEPS];
   sqrt_lane_type        sq_ff      [SQRT_STEPS];
   sqrt_lane_type        sq_in      [SQRT_STEPS];

   // One quotient bit: shift in the next dividend bit, subtract when it fits
   function automatic div_lane_type div_step(input div_lane_type p,
                                             input logic [PROD_BITS-1:0] d);
      logic [PROD_BITS:0] sh;
      logic [PROD_BITS:0] diff;
      logic               qb;
      div_lane_type       n;
      sh    = {p.rem, p.num[PROD_BITS-1]};
      diff  = sh - {1'b0, d};
      qb    = (sh >= {1'b0, d});
      n.num = {p.num[PROD_BITS-2:0], 1'b0};
      n.rem = qb ? diff[PROD_BITS-1:0] : sh[PROD_BITS-1:0];
      n.q   = {p.q[QUO_BITS-2:0], qb};
      n.big = p.big | p.q[QUO_BITS-1];
      return n;
   endfunction

   // One root bit from the next two radicand bits
   function automatic sqrt_lane_type sqrt_step(input sqrt_lane_type p);
      logic [WORD_BITS+3:0] sh;
      logic [WORD_BITS+3:0] trial;
      logic [WORD_BITS+3:0] diff;
      logic                 ge;
      sqrt_lane_type        n;
      sh     = {p.rem, p.x[PROD_BITS-1:PROD_BITS-2]};
      trial  = {2'b00, p.root, 2'b01};
      diff   = sh - trial;
      ge     = (sh >= trial);
      n.x    = {p.x[PROD_BITS-3:0], 2'b00};
      n.rem  = ge ? diff[WORD_BITS+1:0] : sh[WORD_BITS+1:0];
      n.root = {p.root[WORD_BITS-2:0], ge};
      return n;
   endfunction

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      logic                 valid_prev;
      side_type             side_prev;
      side_type             side_in;
      div_lane_type         re_prev;
      div_lane_type         im_prev;
      logic [PROD_BITS-1:0] div_prev;

      // Pick the previous stage or the module input
      if (k == 0) begin : g_first
         assign valid_prev = in_valid;
         assign side_prev  = in_side;
         assign re_prev    = in_lane_re;
         assign im_prev    = in_lane_im;
         assign div_prev   = in_divisor;
      end else begin : g_next
         assign valid_prev = valid_ff[k-1];
         assign side_prev  = side_ff[k-1];
         assign re_prev    = re_ff[k-1];
         assign im_prev    = im_ff[k-1];
         assign div_prev   = divisor_ff[k-1];
      end

      // Square root runs in the leading stages
      if (k < SQRT_STEPS) begin : g_sqrt
         sqrt_lane_type sq_prev;
         if (k == 0) begin : g_sq_first
            always_comb begin
               sq_prev   = '0;
               sq_prev.x = in_lane_re.num;
            end
         end else begin : g_sq_next
            assign sq_prev = sq_ff[k-1];
         end
         assign sq_in[k] = sqrt_step(sq_prev);
         always_ff @(posedge clock) begin
            if (adv) begin
               sq_ff[k] <= sq_in[k];
            end
         end
      end

      // Drop the finished root into the result for magnitude items
      if (k == SQRT_STEPS - 1) begin : g_root
         always_comb begin
            side_in = side_prev;
            if (side_prev.is_mag) begin
               side_in.re     = sq_in[k].root[WORD_BITS-1] ? WORD_MAX : sq_in[k].root;
               side_in.status = sq_in[k].root[WORD_BITS-1] ? STAT_SAT : STAT_OK;
            end
         end
      end else begin : g_pass
         assign side_in = side_prev;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv) begin
            valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            side_ff[k]    <= side_in;
            re_ff[k]      <= div_step(re_prev, div_prev);
            im_ff[k]      <= div_step(im_prev, div_prev);
            divisor_ff[k] <= div_prev;
         end
      end
   end

   assign out_valid   = valid_ff[DIV_STEPS-1];
   assign out_side    = side_ff[DIV_STEPS-1];
   assign out_lane_re = re_ff[DIV_STEPS-1];
   assign out_lane_im = im_ff[DIV_STEPS-1];

endmodule

`default_nettype wire

[hdl/cau_back.sv]
// Back end: quotient rounding, division status and the result output register.
`default_nettype none

module cau_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  cau_pkg::side_type             in_side,
   input  cau_pkg::div_lane_type         in_lane_re,
   input  cau_pkg::div_lane_type         in_lane_im,
   output logic                          out_valid,
   output logic [cau_pkg::WORD_BITS-1:0] out_re,
   output logic [cau_pkg::WORD_BITS-1:0] out_im,
   output cau_pkg::status_type           out_status,
   output logic                          out_eq
);
   import cau_pkg::*;

   logic [QUO_BITS:0]    q_re_inc, q_im_inc;
   clamp_type            c_re, c_im;
   logic                 sat;
   logic [WORD_BITS-1:0] re_in, im_in;
   status_type           status_in;

   logic                 valid_ff;
   logic [WORD_BITS-1:0] re_ff, im_ff;
   status_type           status_ff;
   logic                 eq_ff;

   // Round quotients half away from zero, then clamp
   always_comb begin
      q_re_inc = ({1'b0, in_lane_re.q} + (QUO_BITS+1)'(1)) >> 1;
      q_im_inc = ({1'b0, in_lane_im.q} + (QUO_BITS+1)'(1)) >> 1;
      c_re = clamp_word(in_side.nr, PROD_BITS'(q_re_inc));
      c_im = clamp_word(in_side.ni, PROD_BITS'(q_im_inc));
      if (in_lane_re.big) begin
         c_re.sat   = 1'b1;
         c_re.value = in_side.nr ? WORD_MIN : WORD_MAX;
      end
      if (in_lane_im.big) begin
         c_im.sat   = 1'b1;
         c_im.value = in_side.ni ? WORD_MIN : WORD_MAX;
      end
      sat = c_re.sat || c_im.sat;

      re_in     = in_side.re;
      im_in     = in_side.im;
      status_in = in_side.status;
      if (in_side.is_div) begin
         if (in_side.dz) begin
            re_in     = '0;
            im_in     = '0;
            status_in = STAT_DIV_ZERO;
         end else begin
            re_in     = c_re.value;
            im_in     = c_im.value;
            status_in = sat ? STAT_SAT : STAT_OK;
         end
      end
   end

   // Hold the result until the receiver takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         re_ff     <= re_in;
         im_ff     <= im_in;
         status_ff <= status_in;
         eq_ff     <= in_side.eq;
      end
   end

   assign out_valid  = valid_ff;
   assign out_re     = re_ff;
   assign out_im     = im_ff;
   assign out_status = status_ff;
   assign out_eq     = eq_ff;

endmodule

`default_nettype wire

[hdl/complex_arithmetic_unit_core.sv]
// Top level of the complex arithmetic unit: pipeline assembly and stream ports.
//
// Usage: one request transaction carries two complex Q16.16 operands a and b in
// req_tdata and the action in req_tuser (add, subtract, multiply, divide, exact
// compare, magnitude of a). Each request gives exactly one response transaction
// with the real and imaginary result and the equal flag in rsp_tdata and the
// status (ok, division by zero, saturated) in rsp_tuser.
// From request acceptance to rsp_tvalid a request passes 4 front stages
// (products, sums, magnitudes, rounding), 81 divider/square-root stages (one
// quotient bit per stage over 64 dividend bits, 16 fraction bits and a rounding
// bit) and the output register. All actions take the same path, so responses
// leave in request order.
// Throughput is one transaction per cycle while the output is not stalled;
// the depth of the bit-per-stage divider sets the latency.
// Reset clears every valid bit; the pipeline is empty afterwards and
// req_tready is high. When the receiver holds rsp_tready low with a result
// waiting, the whole pipeline freezes and req_tready drops; nothing is lost.
`default_nettype none

module complex_arithmetic_unit_core (
   input  logic                                  clock,
   input  logic                                  reset,
   // a_re, a_im, b_re, b_im (32 bits each, lowest bit first)
   input  logic [cau_pkg::REQ_DATA_BITS-1:0]     req_tdata,
   // action
   input  logic [cau_pkg::ACT_BITS-1:0]          req_tuser,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // res_re, res_im, is_equal, zero fill
   output logic [cau_pkg::RSP_DATA_BITS-1:0]     rsp_tdata,
   // status
   output logic [1:0]                            rsp_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready
);
   import cau_pkg::*;

   logic                 adv;
   logic                 f_valid;
   side_type             f_side;
   div_lane_type         f_lane_re, f_lane_im;
   logic [PROD_BITS-1:0] f_divisor;
   logic                 i_valid;
   side_type             i_side;
   div_lane_type         i_lane_re, i_lane_im;
   logic [WORD_BITS-1:0] res_re, res_im;
   status_type           res_status;
   logic                 res_eq;

   // Advance the whole pipeline unless a result is stuck at the output
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   cau_front u_front (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (req_tvalid),
      .in_action   (req_tuser),
      .in_a_re     (req_tdata[WORD_BITS-1:0]),
      .in_a_im     (req_tdata[2*WORD_BITS-1:WORD_BITS]),
      .in_b_re     (req_tdata[3*WORD_BITS-1:2*WORD_BITS]),
      .in_b_im     (req_tdata[4*WORD_BITS-1:3*WORD_BITS]),
      .out_valid   (f_valid),
      .out_side    (f_side),
      .out_lane_re (f_lane_re),
      .out_lane_im (f_lane_im),
      .out_divisor (f_divisor)
   );

   cau_divsqrt u_divsqrt (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (f_valid),
      .in_side     (f_side),
      .in_lane_re  (f_lane_re),
      .in_lane_im  (f_lane_im),
      .in_divisor  (f_divisor),
      .out_valid   (i_valid),
      .out_side    (i_side),
      .out_lane_re (i_lane_re),
      .out_lane_im (i_lane_im)
   );

   cau_back u_back (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_valid   (i_valid),
      .in_side    (i_side),
      .in_lane_re (i_lane_re),
      .in_lane_im (i_lane_im),
      .out_valid  (rsp_tvalid),
      .out_re     (res_re),
      .out_im     (res_im),
      .out_status (res_status),
      .out_eq     (res_eq)
   );

   // Pack the response
   assign rsp_tdata = {(RSP_DATA_BITS - 2*WORD_BITS - 1)'(0), res_eq, res_im, res_re};
   assign rsp_tuser = res_status;

   // Division by zero returns a zero result
   a_div_zero_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == STAT_DIV_ZERO) |-> rsp_tdata[2*WORD_BITS-1:0] == '0)
      else $error("division by zero with nonzero result");

   // A compare hit carries a zero result and ok status
   a_equal_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[2*WORD_BITS]) |->
         (rsp_tuser == STAT_OK && rsp_tdata[2*WORD_BITS-1:0] == '0))
      else $error("equal flag with nonzero result or status");

   // A blocked output must stop the input side
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("request taken while output stalled");

   // Output stays valid through a stall
   a_stall_holds_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid)
      else $error("result dropped during stall");

endmodule

`default_nettype wire
